>>> design/pcr_pkg.sv
// pcr_pkg: shared types and constants for the pulse capture and replay block
// beat structs, mode and controller state enums, command and status bundles
// no dependencies
package pcr_pkg;

    localparam int DUR_W      = 16;
    localparam int TRANS_W    = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int MINTR_W    = 9;
    localparam int REPEAT_W   = 4;

    localparam logic [DUR_W-1:0] DUR_MAX = {DUR_W{1'b1}};

    // action codes
    localparam logic [1:0] ACT_TICK    = 2'd0;
    localparam logic [1:0] ACT_CONFIRM = 2'd1;
    localparam logic [1:0] ACT_CANCEL  = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MIN_PULSE_LEN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IDLE_TIMEOUT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_TRANSITIONS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_COUNT    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_GAP      = 3'd4;

    // register reset values
    localparam logic [DUR_W-1:0]    RST_MIN_PULSE_LEN   = 16'd60;
    localparam logic [DUR_W-1:0]    RST_IDLE_TIMEOUT    = 16'd50000;
    localparam logic [MINTR_W-1:0]  RST_MIN_TRANSITIONS = 9'd20;
    localparam logic [REPEAT_W-1:0] RST_REPEAT_COUNT    = 4'd3;
    localparam logic [DUR_W-1:0]    RST_REPEAT_GAP      = 16'd12000;

    typedef struct packed {
        logic [1:0] action;
        logic       sample_level;
    } s_beat_t;

    typedef struct packed {
        logic               drive_level;
        logic               drive_enable;
        logic               burst_ready;
        logic [TRANS_W-1:0] transitions;
        logic               overflowed;
    } m_beat_t;

    typedef enum logic [1:0] {
        MODE_CAPTURE,
        MODE_HELD,
        MODE_REPLAY
    } mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_LOAD,
        ST_READ,
        ST_EMIT
    } ctrl_state_t;

    typedef struct packed {
        logic latch;
        logic capture;
        logic track;
        logic tick_down;
        logic idx_inc;
        logic start_replay;
        logic end_burst;
        logic load_gap;
        logic idx_past_gap;
        logic pass_inc;
        logic mem_read;
        logic load_rec;
        logic emit;
    } cmd_t;

    typedef struct packed {
        mode_t      mode;
        logic [1:0] action;
        logic       ticks_dec_zero;
        logic       idx_lt_count;
        logic       idx_le_count;
        logic       gap_zero;
        logic       pass_final;
        logic       rep_zero;
        logic       rd_dur_zero;
        logic       out_free;
    } status_t;

endpackage

>>> design/pcr_datapath.sv
// pcr_datapath: configuration registers, capture counters, pulse store and
// replay counters, plus the result register; driven by commands from pcr_ctrl
// depends on pcr_pkg
module pcr_datapath #(
    parameter int STORE_DEPTH = 512
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [pcr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pcr_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  pcr_pkg::s_beat_t                s_data,
    input  pcr_pkg::cmd_t                   cmd,
    output pcr_pkg::status_t                status,
    output logic                            m_valid,
    input  logic                            m_ready,
    output pcr_pkg::m_beat_t                m_data
);
    import pcr_pkg::*;

    localparam int AW    = $clog2(STORE_DEPTH);
    localparam int CNT_W = $clog2(STORE_DEPTH + 1);
    localparam int IDX_W = $clog2(STORE_DEPTH + 2);
    localparam int CMP_W = (CNT_W > MINTR_W) ? CNT_W : MINTR_W;
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(STORE_DEPTH);

    // configuration
    logic [DUR_W-1:0]    min_pulse_reg;
    logic [DUR_W-1:0]    idle_timeout_reg;
    logic [MINTR_W-1:0]  min_trans_reg;
    logic [REPEAT_W-1:0] repeat_count_reg;
    logic [DUR_W-1:0]    repeat_gap_reg;

    // burst state
    mode_t               mode_reg,   mode_next;
    logic                prev_reg,   prev_next;
    logic [DUR_W-1:0]    elapsed_reg, elapsed_next;
    logic [CNT_W-1:0]    count_reg,  count_next;
    logic                ovf_reg,    ovf_next;
    logic [IDX_W-1:0]    idx_reg,    idx_next;
    logic [DUR_W-1:0]    ticks_reg,  ticks_next;
    logic [REPEAT_W-1:0] passes_reg, passes_next;
    logic                line_reg,   line_next;

    s_beat_t             item_reg;
    logic [DUR_W:0]      rd_reg;
    logic                m_valid_reg;
    m_beat_t             m_data_reg, m_data_next;

    logic [DUR_W:0]      store_mem [STORE_DEPTH];

    logic [DUR_W-1:0]    el_inc;
    logic [DUR_W-1:0]    el_cap;
    logic [CNT_W-1:0]    count_cap;
    logic                changed;
    logic                accepted;
    logic                has_room;
    logic                mem_we;
    logic                timeout;
    logic                keep;
    logic                capture_drop;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_pulse_reg    <= RST_MIN_PULSE_LEN;
            idle_timeout_reg <= RST_IDLE_TIMEOUT;
            min_trans_reg    <= RST_MIN_TRANSITIONS;
            repeat_count_reg <= RST_REPEAT_COUNT;
            repeat_gap_reg   <= RST_REPEAT_GAP;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_MIN_PULSE_LEN:   min_pulse_reg    <= cfg_wdata;
                REG_IDLE_TIMEOUT:    idle_timeout_reg <= cfg_wdata;
                REG_MIN_TRANSITIONS: min_trans_reg    <= cfg_wdata[MINTR_W-1:0];
                REG_REPEAT_COUNT:    repeat_count_reg <= cfg_wdata[REPEAT_W-1:0];
                REG_REPEAT_GAP:      repeat_gap_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // one capture tick, computed combinationally
    always_comb begin
        el_inc    = (elapsed_reg != DUR_MAX) ? elapsed_reg + DUR_W'(1) : elapsed_reg;
        changed   = item_reg.sample_level != prev_reg;
        accepted  = changed && (el_inc >= min_pulse_reg);
        has_room  = count_reg < DEPTH_C;
        mem_we    = cmd.capture && accepted && has_room;
        el_cap    = accepted ? '0 : el_inc;
        count_cap = (accepted && has_room) ? count_reg + CNT_W'(1) : count_reg;
        timeout   = (count_cap != '0) && ((el_cap > idle_timeout_reg) || (el_cap == DUR_MAX));
        keep      = CMP_W'(count_cap) > CMP_W'(min_trans_reg);
        capture_drop = cmd.capture && timeout && !keep;
    end

    always_comb begin
        mode_next   = mode_reg;
        prev_next   = prev_reg;
        elapsed_next = elapsed_reg;
        count_next  = count_reg;
        ovf_next    = ovf_reg;
        idx_next    = idx_reg;
        ticks_next  = ticks_reg;
        passes_next = passes_reg;
        line_next   = line_reg;

        if (cmd.capture) begin
            prev_next    = item_reg.sample_level;
            elapsed_next = el_cap;
            count_next   = count_cap;
            if (accepted && !has_room) begin
                ovf_next = 1'b1;
            end
            if (timeout && keep) begin
                mode_next = MODE_HELD;
            end
        end
        if (cmd.track) begin
            prev_next = item_reg.sample_level;
        end
        if (cmd.tick_down && (ticks_reg != '0)) begin
            ticks_next = ticks_reg - DUR_W'(1);
        end
        if (cmd.idx_inc) begin
            idx_next = idx_reg + IDX_W'(1);
        end
        if (cmd.start_replay) begin
            mode_next   = MODE_REPLAY;
            passes_next = '0;
            idx_next    = IDX_W'(1);
        end
        if (cmd.load_gap) begin
            idx_next   = IDX_W'(count_reg);
            ticks_next = repeat_gap_reg;
        end
        if (cmd.idx_past_gap) begin
            idx_next = IDX_W'(count_reg) + IDX_W'(1);
        end
        if (cmd.pass_inc) begin
            passes_next = passes_reg + REPEAT_W'(1);
            idx_next    = IDX_W'(1);
        end
        if (cmd.load_rec) begin
            ticks_next = rd_reg[DUR_W-1:0];
            line_next  = rd_reg[DUR_W];
        end
        // burst over: back to capture with an empty store
        if (cmd.end_burst || capture_drop) begin
            mode_next    = MODE_CAPTURE;
            count_next   = '0;
            ovf_next     = 1'b0;
            elapsed_next = '0;
            idx_next     = '0;
            ticks_next   = '0;
            passes_next  = '0;
            line_next    = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= MODE_CAPTURE;
            prev_reg    <= 1'b0;
            elapsed_reg <= '0;
            count_reg   <= '0;
            ovf_reg     <= 1'b0;
            idx_reg     <= '0;
            ticks_reg   <= '0;
            passes_reg  <= '0;
            line_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            mode_reg    <= mode_next;
            prev_reg    <= prev_next;
            elapsed_reg <= elapsed_next;
            count_reg   <= count_next;
            ovf_reg     <= ovf_next;
            idx_reg     <= idx_next;
            ticks_reg   <= ticks_next;
            passes_reg  <= passes_next;
            line_reg    <= line_next;
            if (cmd.emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            item_reg <= s_data;
        end
        if (cmd.emit) begin
            m_data_reg <= m_data_next;
        end
    end

    // pulse store: written at the fill count, read at the replay index
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            store_mem[count_reg[AW-1:0]] <= {~item_reg.sample_level, el_inc};
        end
        if (cmd.mem_read) begin
            rd_reg <= store_mem[idx_reg[AW-1:0]];
        end
    end

    always_comb begin
        m_data_next.drive_level  = (mode_reg == MODE_REPLAY) && line_reg;
        m_data_next.drive_enable = mode_reg == MODE_REPLAY;
        m_data_next.burst_ready  = mode_reg == MODE_HELD;
        m_data_next.transitions  = TRANS_W'(count_reg);
        m_data_next.overflowed   = ovf_reg;
    end

    always_comb begin
        status.mode           = mode_reg;
        status.action         = item_reg.action;
        status.ticks_dec_zero = ticks_reg <= DUR_W'(1);
        status.idx_lt_count   = idx_reg < IDX_W'(count_reg);
        status.idx_le_count   = idx_reg <= IDX_W'(count_reg);
        status.gap_zero       = repeat_gap_reg == '0;
        status.pass_final     = ({1'b0, passes_reg} + (REPEAT_W + 1)'(1))
                                >= {1'b0, repeat_count_reg};
        status.rep_zero       = repeat_count_reg == '0;
        status.rd_dur_zero    = rd_reg[DUR_W-1:0] == '0;
        status.out_free       = !m_valid_reg || m_ready;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

>>> design/pcr_ctrl.sv
// pcr_ctrl: sequencer for one beat at a time: execute, walk replay segments,
// read the pulse store, hand the result to the output register
// depends on pcr_pkg
module pcr_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  pcr_pkg::status_t status,
    output pcr_pkg::cmd_t    cmd
);
    import pcr_pkg::*;

    ctrl_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                state_next = ST_EMIT;
                if ((status.action == ACT_TICK) && (status.mode == MODE_REPLAY)
                    && status.ticks_dec_zero) begin
                    state_next = ST_LOAD;
                end
                if ((status.action == ACT_CONFIRM) && (status.mode == MODE_HELD)
                    && !status.rep_zero) begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                priority if (status.idx_lt_count) begin
                    state_next = ST_READ;
                end else if (status.idx_le_count) begin
                    state_next = status.gap_zero ? ST_LOAD : ST_EMIT;
                end else begin
                    state_next = status.pass_final ? ST_EMIT : ST_LOAD;
                end
            end
            ST_READ: begin
                state_next = status.rd_dur_zero ? ST_LOAD : ST_EMIT;
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready   = 1'b1;
                cmd.latch = s_valid;
            end
            ST_EXEC: begin
                unique case (status.action)
                    ACT_TICK: begin
                        if (status.mode == MODE_CAPTURE) begin
                            cmd.capture = 1'b1;
                        end else begin
                            cmd.track = 1'b1;
                        end
                        if (status.mode == MODE_REPLAY) begin
                            cmd.tick_down = 1'b1;
                            cmd.idx_inc   = status.ticks_dec_zero;
                        end
                    end
                    ACT_CONFIRM: begin
                        if (status.mode == MODE_HELD) begin
                            cmd.end_burst    = status.rep_zero;
                            cmd.start_replay = !status.rep_zero;
                        end
                    end
                    ACT_CANCEL: begin
                        cmd.end_burst = status.mode == MODE_HELD;
                    end
                    default: ;
                endcase
            end
            ST_LOAD: begin
                priority if (status.idx_lt_count) begin
                    cmd.mem_read = 1'b1;
                end else if (status.idx_le_count) begin
                    // gap segment after the last record
                    cmd.load_gap     = !status.gap_zero;
                    cmd.idx_past_gap = status.gap_zero;
                end else begin
                    cmd.end_burst = status.pass_final;
                    cmd.pass_inc  = !status.pass_final;
                end
            end
            ST_READ: begin
                cmd.load_rec = 1'b1;
                cmd.idx_inc  = status.rd_dur_zero;
            end
            ST_EMIT: begin
                cmd.emit = status.out_free;
            end
            default: ;
        endcase
    end

endmodule

>>> design/pulse_capture_replay_top.sv
// pulse_capture_replay_top: pulse width capture of a sampled line and replay
// joins the sequencer pcr_ctrl to pcr_datapath; depends on pcr_pkg
//
//   port group     direction   beat contents
//   s_*            in          action, sample_level
//   m_*            out         drive_level, drive_enable, burst_ready,
//                              transitions, overflowed
//   cfg_*          in          register index and write data, no read-back
//
// a beat passes accept, execute and result states, waiting in result while the
// result register is busy; a confirm starting replay, or a replay tick ending
// a segment, adds load and read states per store read and a load state per gap
// or pass step; a new beat is taken while the previous result still waits on
// m_ready; reset is synchronous and active low; the store holds no reset and
// needs no clearing pass, since only written entries are ever read back
module pulse_capture_replay_top #(
    parameter int STORE_DEPTH = 512
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [pcr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pcr_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  pcr_pkg::s_beat_t                s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output pcr_pkg::m_beat_t                m_data
);
    import pcr_pkg::*;

    cmd_t    cmd;
    status_t status;

    pcr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    pcr_datapath #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_data    (s_data),
        .cmd       (cmd),
        .status    (status),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

>>> design/pcr_checker.sv
// pcr_checker: port-level checks on pulse_capture_replay_top, bound below
// depends on pcr_pkg and the top level
module pcr_checker (
    input logic             aclk,
    input logic             aresetn,
    input logic             s_valid,
    input logic             s_ready,
    input logic             m_valid,
    input logic             m_ready,
    input pcr_pkg::m_beat_t m_data
);

    // no result survives reset
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result beat valid after reset");

    // one beat in flight: the input side closes right after an accept
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted on consecutive cycles");

    // held and replaying never overlap
    a_modes_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_data.drive_enable && m_data.burst_ready))
        else $error("burst held and replaying at once");

    // line driven high only while replay owns it
    a_level_needs_enable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.drive_level |-> m_data.drive_enable)
        else $error("drive level high without drive enable");

    // stalled result holds
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result beat changed");

endmodule

bind pulse_capture_replay_top pcr_checker u_pcr_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
